/* hdl/tbrl_pkg.sv */
// Shared widths, register codes, reset values and types of the token bucket limiter.
package tbrl_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 48;
  localparam int unsigned CAP_W          = 16;
  localparam int unsigned PERIOD_W       = 32;
  localparam int unsigned RUN_W          = 32;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 1'b1;

  localparam logic [CAP_W-1:0]    CAP_RESET    = 16'd16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;
  localparam logic [RUN_W-1:0]    RUN_MAX      = {RUN_W{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/tbrl_div.sv */
// Restoring shift-subtract divider: one quotient bit per cycle.
module tbrl_div #(
  parameter int unsigned TIME_WIDTH = tbrl_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [TIME_WIDTH-1:0]         dividend_i,
  input  logic [tbrl_pkg::PERIOD_W-1:0] divisor_i,
  output tbrl_pkg::div_stat_t           stat_o,
  output logic [TIME_WIDTH-1:0]         quotient_o,
  output logic [tbrl_pkg::PERIOD_W-1:0] remainder_o
);

  localparam int unsigned PW    = tbrl_pkg::PERIOD_W;
  localparam int unsigned CNT_W = $clog2(TIME_WIDTH + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TIME_WIDTH - 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [TIME_WIDTH-1:0] quo_q;
  logic [PW-1:0]         rem_q;
  logic [PW-1:0]         div_q;

  logic [PW:0] shifted;
  logic [PW:0] diff;
  logic        fits;

  // Bring down the next dividend bit and try the subtraction
  assign shifted = {rem_q, quo_q[TIME_WIDTH-1]};
  assign fits    = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[TIME_WIDTH-2:0], fits};
      rem_q <= fits ? diff[PW-1:0] : shifted[PW-1:0];
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

/* hdl/token_bucket_rate_limiter.sv */
// Token bucket rate limiter: request sequencer, bucket state and result register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//   in      | in        | in_valid_i / in_ready_o | now_time_i
//   out     | out       | out_valid_o/out_ready_i | granted_o, suppressed_count_o
//
// A request that needs a refill passes through the serial divider, which yields one
// quotient bit per cycle, and then the update state; the first request and a timestamp
// behind the anchor skip the divider and go straight to the update state.
// in_ready_o is high only while the sequencer is idle; one request is in work at a time.
// A result waits in the output register; a stalled output holds the next request in
// its final step. Reset loads capacity 16, period 1000 and a full bucket; no clearing pass.
module token_bucket_rate_limiter #(
  parameter int unsigned TIME_WIDTH = tbrl_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tbrl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [TIME_WIDTH-1:0]           now_time_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            granted_o,
  output logic [tbrl_pkg::RUN_W-1:0]      suppressed_count_o
);

  localparam int unsigned CW = tbrl_pkg::CAP_W;
  localparam int unsigned PW = tbrl_pkg::PERIOD_W;
  localparam int unsigned RW = tbrl_pkg::RUN_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         cap_q;
  logic [PW-1:0]         period_q;
  logic                  anchored_q;
  logic [TIME_WIDTH-1:0] last_q;
  logic [CW-1:0]         tokens_q;
  logic [RW-1:0]         run_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic                  skip_q;
  logic                  out_valid_q;
  logic                  granted_q;
  logic [RW-1:0]         supp_q;

  tbrl_pkg::div_stat_t   div_stat;
  logic [TIME_WIDTH-1:0] quotient;
  logic [PW-1:0]         remainder;

  logic                  in_accept;
  logic                  behind;
  logic                  div_start;
  logic                  commit;
  logic [CW-1:0]         room;
  logic [CW-1:0]         refilled;
  logic [CW-1:0]         cfg_cap;
  logic [PW-1:0]         cfg_period;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign behind     = now_time_i < last_q;
  assign div_start  = in_accept && anchored_q && !behind;
  assign commit     = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);

  // Zero capacity or period behaves as one
  assign cfg_cap    = (cfg_data_i[CW-1:0] == '0) ? CW'(1) : cfg_data_i[CW-1:0];
  assign cfg_period = (cfg_data_i[PW-1:0] == '0) ? PW'(1) : cfg_data_i[PW-1:0];

  assign room = cap_q - tokens_q;

  always_comb begin
    if (skip_q) begin
      refilled = tokens_q;
    end else if (quotient >= TIME_WIDTH'(room)) begin
      refilled = cap_q;
    end else begin
      refilled = tokens_q + quotient[CW-1:0];
    end
  end

  tbrl_div #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (now_time_i - last_q),
    .divisor_i  (period_q),
    .stat_o     (div_stat),
    .quotient_o (quotient),
    .remainder_o(remainder)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = div_start ? ST_DIV : ST_UPD;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= tbrl_pkg::CAP_RESET;
      period_q    <= tbrl_pkg::PERIOD_RESET;
      anchored_q  <= 1'b0;
      last_q      <= '0;
      tokens_q    <= tbrl_pkg::CAP_RESET;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          tbrl_pkg::REG_CAPACITY: begin
            cap_q    <= cfg_cap;
            tokens_q <= cfg_cap;
          end
          tbrl_pkg::REG_PERIOD: period_q <= cfg_period;
          default: ;
        endcase
      end

      // Anchor on the first request, re-anchor when time runs backwards
      if (in_accept && !div_start) begin
        anchored_q <= 1'b1;
        last_q     <= now_time_i;
      end

      if (commit) begin
        out_valid_q <= 1'b1;
        // Advance the anchor by whole periods: now minus the leftover part
        if (!skip_q) begin
          last_q <= now_q - TIME_WIDTH'(remainder);
        end
        if (refilled == '0) begin
          tokens_q <= refilled;
          if (run_q != tbrl_pkg::RUN_MAX) begin
            run_q <= run_q + RW'(1);
          end
        end else begin
          tokens_q <= refilled - CW'(1);
          run_q    <= '0;
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q  <= now_time_i;
      skip_q <= !div_start;
    end
    if (commit) begin
      granted_q <= (refilled != '0);
      supp_q    <= (refilled != '0) ? run_q : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign granted_o          = granted_q;
  assign suppressed_count_o = supp_q;

endmodule

/* hdl/tbrl_chk.sv */
// Port-level checks of the token bucket limiter, bound to the top level.
module tbrl_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       granted_o,
  input logic [tbrl_pkg::RUN_W-1:0] suppressed_count_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_o)
      && $stable(suppressed_count_o))
    else $error("result word changed while stalled");

  // A denial never reports a count
  a_deny_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> suppressed_count_o == '0)
    else $error("denied word carries a nonzero count");

  // One request at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while the previous one is in work");

  // A new result appears only out of a busy sequencer
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a request in work");

endmodule

bind token_bucket_rate_limiter tbrl_chk u_tbrl_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .granted_o         (granted_o),
  .suppressed_count_o(suppressed_count_o)
);
